@@ src/pts_pkg.sv @@
// Shared types, constants and codes of the process table scheduler.
`timescale 1ns / 1ps
package pts_pkg;

	localparam int NUM_SLOTS = 64;
	localparam int IDX_W = $clog2(NUM_SLOTS);
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam logic [31:0] PRIO_STEP = 32'd5;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_NONE = 2'd1;
	localparam logic [1:0] STAT_ERR = 2'd2;

	localparam logic [1:0] POL_RR_Q = 2'd1;
	localparam logic [1:0] POL_PRIO = 2'd2;

	localparam logic [1:0] CFG_POLICY = 2'd0;
	localparam logic [1:0] CFG_QUANTUM = 2'd1;

	localparam logic [3:0] OPCODE_MAX = 4'd9;

	typedef enum logic [2:0] {
		ST_UNUSED, ST_EMBRYO, ST_SLEEPING, ST_RUNNABLE, ST_RUNNING, ST_ZOMBIE
	} slot_state_t;

	typedef enum logic [3:0] {
		OP_ALLOC, OP_RUNNABLE, OP_PICK, OP_TICK, OP_YIELD, OP_SLEEP,
		OP_WAKEUP, OP_KILL, OP_EXIT, OP_REAP, OP_BAD
	} op_t;

	typedef enum logic [2:0] {
		E_IDLE, E_SCAN, E_POST, E_WR, E_MOD, E_DONE
	} eng_state_t;

	typedef struct packed {
		op_t op;
		logic slot_ok;
		logic [IDX_W-1:0] idx;
		logic [30:0] pid;
		logic [31:0] chan;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] chosen;
		logic [30:0] pid;
		logic [31:0] creation;
		logic [31:0] termination;
		logic [31:0] sleeping;
		logic [31:0] ready;
		logic [31:0] running;
	} res_t;

	typedef struct packed {
		slot_state_t state;
		logic [30:0] pid;
		logic [31:0] chan;
		logic killed;
		logic got_cpu;
		logic [31:0] prio;
		logic [31:0] creation;
		logic [31:0] termination;
		logic [31:0] sleeping;
		logic [31:0] ready;
		logic [31:0] running;
	} slot_t;

endpackage

@@ src/pts_front.sv @@
// Front end: accept beats, decode the opcode and queue commands for the engine.
`timescale 1ns / 1ps
module pts_front import pts_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [3:0] opcode,
	input logic [5:0] slot,
	input logic [30:0] pid,
	input logic [31:0] channel,
	output logic cmd_valid,
	output cmd_t cmd,
	input logic cmd_pop
);

	cmd_t ent_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QPTR_W:0] cnt_q;
	cmd_t dec;
	logic wr, rd;

	always_comb begin
		dec.op = (opcode > OPCODE_MAX) ? OP_BAD : op_t'(opcode);
		dec.slot_ok = (9'(slot) < 9'(NUM_SLOTS));
		dec.idx = IDX_W'(slot);
		dec.pid = pid;
		dec.chan = channel;
	end

	assign full = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd = ent_q[rptr_q];
	assign wr = push && !full;
	assign rd = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (wr) begin
			ent_q[wptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= (32'(wptr_q) == QDEPTH - 1) ? '0 : wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= (32'(rptr_q) == QDEPTH - 1) ? '0 : rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (QPTR_W+1)'(wr) - (QPTR_W+1)'(rd);
		end
	end

endmodule

@@ src/pts_engine.sv @@
// Back end: slot table memory and the sequencer that carries out each command.
`timescale 1ns / 1ps
module pts_engine import pts_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic [1:0] policy,
	input logic [7:0] quantum,
	input logic cmd_valid,
	input cmd_t cmd,
	output logic cmd_pop,
	input logic res_full,
	output logic res_push,
	output res_t res
);

	localparam logic [IDX_W:0] NW = (IDX_W+1)'(NUM_SLOTS);

	slot_t mem [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] vld_q;

	eng_state_t state_q, state_d;
	cmd_t cmd_q, cmd_d;
	logic [IDX_W:0] k_q, k_d;
	logic [IDX_W-1:0] base_q, base_d;
	logic lag_vld_s1;
	logic [IDX_W-1:0] lag_addr_s1;
	slot_t rdata_s1;
	logic rvld_s1;
	logic found_q, found_d, minf_q, minf_d;
	logic [IDX_W-1:0] found_idx_q, found_idx_d, best_q, best_d, tgt_q, tgt_d;
	logic [31:0] min_q, min_d;
	res_t res_q, res_d;
	logic [31:0] tick_q, tick_d;
	logic [30:0] next_id_q, next_id_d, nid;
	logic [IDX_W-1:0] sptr_q, sptr_d;
	logic [7:0] rem_q, rem_d;
	logic [4:0] bit_q, bit_d;

	logic rd_en, wr_en;
	logic [IDX_W-1:0] rd_addr, wr_addr;
	slot_t wr_data, cur, upd;
	logic [IDX_W:0] sum, nxt;
	logic [32:0] psum;
	logic [8:0] qv, t;
	logic pick_ok;
	logic [IDX_W-1:0] pick_idx;

	assign cur = rvld_s1 ? rdata_s1 : '0;
	assign res = res_q;

	always_comb begin
		state_d = state_q;
		cmd_d = cmd_q;
		k_d = k_q;
		base_d = base_q;
		found_d = found_q;
		found_idx_d = found_idx_q;
		minf_d = minf_q;
		min_d = min_q;
		best_d = best_q;
		tgt_d = tgt_q;
		res_d = res_q;
		tick_d = tick_q;
		next_id_d = next_id_q;
		sptr_d = sptr_q;
		rem_d = rem_q;
		bit_d = bit_q;
		cmd_pop = 1'b0;
		res_push = 1'b0;
		rd_en = 1'b0;
		wr_en = 1'b0;
		upd = cur;

		sum = {1'b0, base_q} + k_q;
		if (sum >= NW) begin
			sum = sum - NW;
		end
		rd_addr = sum[IDX_W-1:0];
		wr_addr = lag_addr_s1;

		nxt = {1'b0, tgt_q} + 1'b1;
		if (nxt >= NW) begin
			nxt = '0;
		end
		psum = {1'b0, cur.prio} + 33'(PRIO_STEP);
		nid = next_id_q + 1'b1;
		if (nid == '0) begin
			nid = 31'd1;
		end
		qv = (quantum == '0) ? 9'd1 : {1'b0, quantum};
		t = {rem_q, cur.running[5'd31 - bit_q]};
		pick_ok = (policy == POL_PRIO) ? minf_q : found_q;
		pick_idx = (policy == POL_PRIO) ? best_q : found_idx_q;

		case (state_q)
			E_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					cmd_d = cmd;
					res_d = '0;
					found_d = 1'b0;
					minf_d = 1'b0;
					k_d = '0;
					base_d = '0;
					tgt_d = cmd.idx;
					case (cmd.op)
						OP_ALLOC, OP_WAKEUP, OP_KILL: begin
							state_d = E_SCAN;
						end
						OP_TICK: begin
							tick_d = tick_q + 1'b1;
							state_d = E_SCAN;
						end
						OP_PICK: begin
							if (policy != POL_PRIO) begin
								base_d = sptr_q;
							end
							state_d = E_SCAN;
						end
						OP_RUNNABLE, OP_YIELD, OP_SLEEP, OP_EXIT, OP_REAP: begin
							if (cmd.slot_ok) begin
								rd_en = 1'b1;
								rd_addr = cmd.idx;
								state_d = E_WR;
							end else begin
								res_d.status = STAT_ERR;
								state_d = E_DONE;
							end
						end
						default: begin
							res_d.status = STAT_ERR;
							state_d = E_DONE;
						end
					endcase
				end
			end
			E_SCAN: begin
				if (k_q != NW) begin
					rd_en = 1'b1;
					k_d = k_q + 1'b1;
				end else begin
					state_d = E_POST;
				end
				if (lag_vld_s1) begin
					case (cmd_q.op)
						OP_ALLOC, OP_PICK: begin
							if (cur.state == ST_RUNNABLE && (!minf_q || cur.prio < min_q)) begin
								minf_d = 1'b1;
								min_d = cur.prio;
								best_d = lag_addr_s1;
							end
							if (!found_q && cur.state ==
								((cmd_q.op == OP_ALLOC) ? ST_UNUSED : ST_RUNNABLE)) begin
								found_d = 1'b1;
								found_idx_d = lag_addr_s1;
							end
						end
						OP_TICK: begin
							case (cur.state)
								ST_RUNNING: upd.running = cur.running + 1'b1;
								ST_SLEEPING: upd.sleeping = cur.sleeping + 1'b1;
								ST_RUNNABLE: begin
									if (cur.got_cpu) begin
										upd.ready = cur.ready + 1'b1;
									end
								end
								ST_EMBRYO: upd.creation = cur.creation + 1'b1;
								default: ;
							endcase
							wr_en = (cur.state != ST_UNUSED);
						end
						OP_WAKEUP: begin
							if (cur.state == ST_SLEEPING && cur.chan == cmd_q.chan) begin
								upd.state = ST_RUNNABLE;
								wr_en = 1'b1;
							end
						end
						OP_KILL: begin
							if (!found_q && cur.state != ST_UNUSED && cur.pid == cmd_q.pid) begin
								found_d = 1'b1;
								upd.killed = 1'b1;
								if (cur.state == ST_SLEEPING) begin
									upd.state = ST_RUNNABLE;
								end
								wr_en = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			E_POST: begin
				state_d = E_DONE;
				case (cmd_q.op)
					OP_ALLOC: begin
						if (!found_q) begin
							res_d.status = STAT_NONE;
						end else begin
							upd = '0;
							upd.state = ST_EMBRYO;
							upd.pid = next_id_q;
							upd.prio = minf_q ? min_q : '0;
							upd.creation = tick_q;
							wr_en = 1'b1;
							wr_addr = found_idx_q;
							next_id_d = nid;
							res_d.chosen = 6'(found_idx_q);
							res_d.pid = next_id_q;
						end
					end
					OP_PICK: begin
						if (!pick_ok) begin
							res_d.status = STAT_NONE;
						end else begin
							rd_en = 1'b1;
							rd_addr = pick_idx;
							tgt_d = pick_idx;
							state_d = E_WR;
						end
					end
					OP_KILL: res_d.status = found_q ? STAT_OK : STAT_ERR;
					default: ;
				endcase
			end
			E_WR: begin
				wr_addr = tgt_q;
				state_d = E_DONE;
				case (cmd_q.op)
					OP_PICK: begin
						upd.state = ST_RUNNING;
						upd.got_cpu = 1'b1;
						if (policy == POL_PRIO) begin
							upd.prio = psum[32] ? '1 : psum[31:0];
						end else begin
							sptr_d = nxt[IDX_W-1:0];
						end
						wr_en = 1'b1;
						res_d.chosen = 6'(tgt_q);
						res_d.pid = cur.pid;
					end
					OP_RUNNABLE: begin
						if (cur.state != ST_EMBRYO) begin
							res_d.status = STAT_ERR;
						end else begin
							upd.state = ST_RUNNABLE;
							wr_en = 1'b1;
						end
					end
					OP_YIELD: begin
						if (cur.state != ST_RUNNING) begin
							res_d.status = STAT_ERR;
						end else if (policy == POL_RR_Q) begin
							rem_d = '0;
							bit_d = '0;
							state_d = E_MOD;
						end else begin
							upd.state = ST_RUNNABLE;
							wr_en = 1'b1;
						end
					end
					OP_SLEEP: begin
						if (cur.state != ST_RUNNING) begin
							res_d.status = STAT_ERR;
						end else begin
							upd.state = ST_SLEEPING;
							upd.chan = cmd_q.chan;
							wr_en = 1'b1;
						end
					end
					OP_EXIT: begin
						if (cur.state != ST_RUNNING) begin
							res_d.status = STAT_ERR;
						end else begin
							upd.state = ST_ZOMBIE;
							upd.termination = tick_q;
							wr_en = 1'b1;
						end
					end
					OP_REAP: begin
						if (cur.state != ST_ZOMBIE) begin
							res_d.status = STAT_ERR;
						end else begin
							res_d.chosen = 6'(tgt_q);
							res_d.pid = cur.pid;
							res_d.creation = cur.creation;
							res_d.termination = cur.termination;
							res_d.sleeping = cur.sleeping;
							res_d.ready = cur.ready;
							res_d.running = cur.running;
							upd.state = ST_UNUSED;
							upd.pid = '0;
							upd.killed = 1'b0;
							wr_en = 1'b1;
						end
					end
					default: ;
				endcase
			end
			E_MOD: begin
				// one remainder bit per cycle, most significant first
				wr_addr = tgt_q;
				rem_d = (t >= qv) ? 8'(t - qv) : t[7:0];
				bit_d = bit_q + 1'b1;
				if (bit_q == 5'd31) begin
					state_d = E_DONE;
					if (rem_d == '0) begin
						upd.state = ST_RUNNABLE;
						wr_en = 1'b1;
					end
				end
			end
			E_DONE: begin
				if (!res_full) begin
					res_push = 1'b1;
					state_d = E_IDLE;
				end
			end
			default: state_d = E_IDLE;
		endcase
		wr_data = upd;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
		lag_addr_s1 <= rd_addr;
		cmd_q <= cmd_d;
		base_q <= base_d;
		found_idx_q <= found_idx_d;
		min_q <= min_d;
		best_q <= best_d;
		tgt_q <= tgt_d;
		res_q <= res_d;
		rem_q <= rem_d;
		bit_q <= bit_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			vld_q <= '0;
			rvld_s1 <= 1'b0;
			lag_vld_s1 <= 1'b0;
			k_q <= '0;
			found_q <= 1'b0;
			minf_q <= 1'b0;
			tick_q <= '0;
			next_id_q <= 31'd1;
			sptr_q <= '0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvld_s1 <= vld_q[rd_addr];
			end
			lag_vld_s1 <= rd_en && (state_q == E_SCAN);
			k_q <= k_d;
			found_q <= found_d;
			minf_q <= minf_d;
			tick_q <= tick_d;
			next_id_q <= next_id_d;
			sptr_q <= sptr_d;
		end
	end

endmodule

@@ src/pts_outq.sv @@
// Result queue between the engine and the result port.
`timescale 1ns / 1ps
module pts_outq import pts_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic res_push,
	input res_t res_in,
	output logic res_full,
	output logic empty,
	input logic pop,
	output res_t res_out
);

	res_t ent_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QPTR_W:0] cnt_q;
	logic wr, rd;

	assign res_full = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign res_out = ent_q[rptr_q];
	assign wr = res_push && !res_full;
	assign rd = pop && !empty;

	always_ff @(posedge clk) begin
		if (wr) begin
			ent_q[wptr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= (32'(wptr_q) == QDEPTH - 1) ? '0 : wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= (32'(rptr_q) == QDEPTH - 1) ? '0 : rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (QPTR_W+1)'(wr) - (QPTR_W+1)'(rd);
		end
	end

endmodule

@@ src/process_table_scheduler.sv @@
// Top level of the process table scheduler: config registers, front, engine, result queue.
//
//  channel  | handshake                 | beat carries
//  ---------+---------------------------+------------------------------------------------
//  command  | push / full               | opcode, slot, pid, channel
//  result   | pop / empty               | status, chosen_slot, out_pid, five time counters
//  config   | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// Alloc, pick, tick, wakeup and kill sweep all 64 slots of the slot memory, one slot
// per cycle; a pick adds one read-modify-write of the chosen slot. A yield under
// policy 1 adds a bit-serial remainder of the running time by the quantum.
// Reset clears the slot valid bits at once, so no clearing pass is needed.
// The front queue keeps taking commands, until it is full, while the engine works or a result waits.
`timescale 1ns / 1ps
module process_table_scheduler import pts_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [3:0] opcode,
	input logic [5:0] slot,
	input logic [30:0] pid,
	input logic [31:0] channel,
	output logic empty,
	input logic pop,
	output logic [1:0] status,
	output logic [5:0] chosen_slot,
	output logic [30:0] out_pid,
	output logic [31:0] creation_time,
	output logic [31:0] termination_time,
	output logic [31:0] sleeping_time,
	output logic [31:0] ready_time,
	output logic [31:0] running_time,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [7:0] cfg_data
);

	logic [1:0] policy_q;
	logic [7:0] quantum_q;
	logic cmd_valid, cmd_pop, res_push, res_full;
	cmd_t cmd;
	res_t res, res_out;

	// Config writes are always taken; indexes past the list are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= '0;
			quantum_q <= 8'd10;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_POLICY: policy_q <= cfg_data[1:0];
				CFG_QUANTUM: quantum_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Decode and buffer incoming command beats.
	pts_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.opcode(opcode),
		.slot(slot),
		.pid(pid),
		.channel(channel),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_pop(cmd_pop)
	);

	// Run each command against the slot table.
	pts_engine u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.policy(policy_q),
		.quantum(quantum_q),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_pop(cmd_pop),
		.res_full(res_full),
		.res_push(res_push),
		.res(res)
	);

	// Hold finished results until the consumer pops them.
	pts_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.res_push(res_push),
		.res_in(res),
		.res_full(res_full),
		.empty(empty),
		.pop(pop),
		.res_out(res_out)
	);

	assign status = res_out.status;
	assign chosen_slot = res_out.chosen;
	assign out_pid = res_out.pid;
	assign creation_time = res_out.creation;
	assign termination_time = res_out.termination;
	assign sleeping_time = res_out.sleeping;
	assign ready_time = res_out.ready;
	assign running_time = res_out.running;

endmodule

@@ sim/tb.sv @@
// Testbench for the process table scheduler: opcode stream against a slot-table predictor.
`timescale 1ns / 1ps
module tb;
	import pts_pkg::*;

	// Slot-table predictor plus the queue of expected result beats.
	class sched_scoreboard;
		slot_state_t st[NUM_SLOTS];
		logic [30:0] spid[NUM_SLOTS];
		logic [31:0] chan[NUM_SLOTS];
		logic killed[NUM_SLOTS];
		logic got_cpu[NUM_SLOTS];
		logic [31:0] prio[NUM_SLOTS];
		logic [31:0] cre[NUM_SLOTS], term[NUM_SLOTS], slp[NUM_SLOTS];
		logic [31:0] rdy[NUM_SLOTS], run[NUM_SLOTS];
		logic [31:0] ticks;
		logic [30:0] next_pid;
		int scan_ptr;
		logic [1:0] policy;
		logic [7:0] quantum;
		res_t pending[$];
		int errors;
		int checked;

		function void clear();
			for (int i = 0; i < NUM_SLOTS; i++) begin
				st[i] = ST_UNUSED; spid[i] = 0; chan[i] = 0; killed[i] = 0; got_cpu[i] = 0;
				prio[i] = 0; cre[i] = 0; term[i] = 0; slp[i] = 0; rdy[i] = 0; run[i] = 0;
			end
			ticks = 0; next_pid = 1; scan_ptr = 0; policy = 0; quantum = 10;
			errors = 0; checked = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [7:0] data);
			if (idx == CFG_POLICY) policy = data[1:0];
			else if (idx == CFG_QUANTUM) quantum = data;
		endfunction

		// lowest priority among runnable slots, first slot on a tie; -1 if none
		function int min_runnable();
			int best;
			best = -1;
			for (int i = 0; i < NUM_SLOTS; i++)
				if (st[i] == ST_RUNNABLE && (best < 0 || prio[i] < prio[best])) best = i;
			return best;
		endfunction

		function void note_command(logic [3:0] opc, logic [5:0] s, logic [30:0] p,
				logic [31:0] ch);
			res_t r;
			int b, hit;
			logic [31:0] q;
			r = '0;
			hit = -1;
			case (opc)
				OP_ALLOC: begin
					b = min_runnable();
					for (int i = 0; i < NUM_SLOTS && hit < 0; i++)
						if (st[i] == ST_UNUSED) hit = i;
					if (hit < 0) r.status = STAT_NONE;
					else begin
						prio[hit] = b < 0 ? 32'd0 : prio[b];
						st[hit] = ST_EMBRYO; spid[hit] = next_pid;
						next_pid = next_pid + 1;
						if (next_pid == 0) next_pid = 1;
						cre[hit] = ticks; term[hit] = 0; slp[hit] = 0;
						rdy[hit] = 0; run[hit] = 0; got_cpu[hit] = 0;
						r.chosen = 6'(hit); r.pid = spid[hit];
					end
				end
				OP_RUNNABLE: if (st[s] != ST_EMBRYO) r.status = STAT_ERR; else st[s] = ST_RUNNABLE;
				OP_PICK: begin
					if (policy == POL_PRIO) begin
						hit = min_runnable();
						if (hit >= 0)
							prio[hit] = prio[hit] > 32'hFFFF_FFFF - PRIO_STEP ? 32'hFFFF_FFFF
								: prio[hit] + PRIO_STEP;
					end else
						for (int k = 0; k < NUM_SLOTS && hit < 0; k++)
							if (st[(scan_ptr + k) % NUM_SLOTS] == ST_RUNNABLE) begin
								hit = (scan_ptr + k) % NUM_SLOTS;
								scan_ptr = (hit + 1) % NUM_SLOTS;
							end
					if (hit < 0) r.status = STAT_NONE;
					else begin
						st[hit] = ST_RUNNING; got_cpu[hit] = 1;
						r.chosen = 6'(hit); r.pid = spid[hit];
					end
				end
				OP_TICK: begin
					ticks++;
					for (int i = 0; i < NUM_SLOTS; i++)
						case (st[i])
							ST_RUNNING: run[i]++;
							ST_SLEEPING: slp[i]++;
							ST_RUNNABLE: if (got_cpu[i]) rdy[i]++;
							ST_EMBRYO: cre[i]++;
							default: ;
						endcase
				end
				OP_YIELD: begin
					q = quantum == 0 ? 32'd1 : {24'd0, quantum};
					if (st[s] != ST_RUNNING) r.status = STAT_ERR;
					else if (policy != POL_RR_Q || run[s] % q == 0) st[s] = ST_RUNNABLE;
				end
				OP_SLEEP: if (st[s] != ST_RUNNING) r.status = STAT_ERR;
					else begin chan[s] = ch; st[s] = ST_SLEEPING; end
				OP_WAKEUP:
					for (int i = 0; i < NUM_SLOTS; i++)
						if (st[i] == ST_SLEEPING && chan[i] == ch) st[i] = ST_RUNNABLE;
				OP_KILL: begin
					r.status = STAT_ERR;
					for (int i = 0; i < NUM_SLOTS && hit < 0; i++)
						if (st[i] != ST_UNUSED && spid[i] == p) begin
							hit = i; killed[i] = 1; r.status = STAT_OK;
							if (st[i] == ST_SLEEPING) st[i] = ST_RUNNABLE;
						end
				end
				OP_EXIT: if (st[s] != ST_RUNNING) r.status = STAT_ERR;
					else begin st[s] = ST_ZOMBIE; term[s] = ticks; end
				OP_REAP: if (st[s] != ST_ZOMBIE) r.status = STAT_ERR;
					else begin
						r.chosen = s; r.pid = spid[s]; r.creation = cre[s];
						r.termination = term[s]; r.sleeping = slp[s];
						r.ready = rdy[s]; r.running = run[s];
						st[s] = ST_UNUSED; spid[s] = 0; killed[s] = 0;
					end
				default: r.status = STAT_ERR;
			endcase
			pending.push_back(r);
		endfunction

		function void check_result(res_t got);
			res_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result beat, actual %p", $time, got);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (got !== e) begin
				$display("%0t: result differs, expected %p, actual %p", $time, e, got);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0, pop = 0, cfg_valid = 0;
	logic [3:0] opcode = 0;
	logic [5:0] slot = 0;
	logic [30:0] pid = 0;
	logic [31:0] channel = 0;
	logic [1:0] cfg_index = 0;
	logic [7:0] cfg_data = 0;
	logic full, empty, cfg_ready;
	logic [1:0] status;
	logic [5:0] chosen_slot;
	logic [30:0] out_pid;
	logic [31:0] creation_time, termination_time, sleeping_time, ready_time, running_time;

	sched_scoreboard board = new();
	bit stall_on = 1;
	int n_ops[16];

	process_table_scheduler dut (.*);

	always #4 clk = ~clk;

	// Receiver: pop steadily while stall_on is clear, else pop at random three times
	// in four; one random phase runs with steady draining, the others with stalls.
	always @(posedge clk) begin
		if (arst_n && !empty && pop)
			board.check_result('{status, chosen_slot, out_pid, creation_time,
				termination_time, sleeping_time, ready_time, running_time});
		if (!stall_on) pop <= 1'b1;
		else pop <= ($urandom_range(0, 3) != 0);
	end

	// Hold one command beat until it is taken; note it in the predictor then.
	task automatic send_cmd(logic [3:0] opc, logic [5:0] s, logic [30:0] p, logic [31:0] ch);
		push <= 1; opcode <= opc; slot <= s; pid <= p; channel <= ch;
		do @(posedge clk); while (full);
		board.note_command(opc, s, p, ch);
		n_ops[opc]++;
	endtask

	task automatic idle_gap(int cycles);
		push <= 0;
		repeat (cycles) @(posedge clk);
	endtask

	// Drain everything, give the engine its sweep time, then write one register.
	task automatic write_reg(logic [1:0] idx, logic [7:0] data);
		idle_gap(1);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(idx, data);
		cfg_valid <= 0;
	endtask

	function automatic logic [5:0] pick_slot();
		int hits[$];
		for (int i = 0; i < NUM_SLOTS; i++)
			if (board.st[i] != ST_UNUSED) hits.push_back(i);
		if (hits.size() == 0 || $urandom_range(0, 5) == 0) return 6'($urandom);
		return 6'(hits[$urandom_range(0, hits.size() - 1)]);
	endfunction

	// Random command, weighted toward a full life cycle on live slots.
	task automatic random_cmd();
		int w;
		logic [31:0] ch;
		logic [30:0] p;
		w = $urandom_range(0, 99);
		ch = $urandom_range(0, 3) == 0 ? $urandom : 32'($urandom_range(0, 3));
		p = $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 70));
		if (w < 14) send_cmd(OP_ALLOC, 6'($urandom), 31'($urandom), $urandom);
		else if (w < 26) send_cmd(OP_RUNNABLE, pick_slot(), p, ch);
		else if (w < 42) send_cmd(OP_PICK, pick_slot(), p, ch);
		else if (w < 56) send_cmd(OP_TICK, pick_slot(), p, ch);
		else if (w < 66) send_cmd(OP_YIELD, pick_slot(), p, ch);
		else if (w < 73) send_cmd(OP_SLEEP, pick_slot(), p, ch);
		else if (w < 79) send_cmd(OP_WAKEUP, pick_slot(), p, ch);
		else if (w < 83) send_cmd(OP_KILL, pick_slot(), p, ch);
		else if (w < 90) send_cmd(OP_EXIT, pick_slot(), p, ch);
		else if (w < 97) send_cmd(OP_REAP, pick_slot(), p, ch);
		else send_cmd(4'($urandom_range(10, 15)), pick_slot(), p, ch);
	endtask

	task automatic random_phase(int count);
		int burst;
		while (count > 0) begin
			burst = $urandom_range(1, 12);
			repeat (burst) begin
				random_cmd();
				count--;
			end
			if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 90));
		end
	endtask

	initial begin
		board.clear();
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: every opcode, field extremes, error paths.
		send_cmd(OP_PICK, 0, 0, 0);              // nothing runnable
		send_cmd(OP_REAP, 6'd63, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_cmd(OP_ALLOC, 0, 0, 0);
		send_cmd(OP_ALLOC, 6'd63, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_cmd(OP_RUNNABLE, 0, 0, 0);
		send_cmd(OP_RUNNABLE, 0, 0, 0);          // wrong state
		send_cmd(OP_RUNNABLE, 1, 0, 0);
		send_cmd(OP_PICK, 0, 0, 0);
		send_cmd(OP_TICK, 0, 0, 0);
		send_cmd(OP_SLEEP, 0, 0, 32'hFFFF_FFFF);
		send_cmd(OP_TICK, 0, 0, 0);
		send_cmd(OP_WAKEUP, 0, 0, 32'hFFFF_FFFF);
		send_cmd(OP_PICK, 0, 0, 0);
		send_cmd(OP_YIELD, 1, 0, 0);
		send_cmd(OP_KILL, 0, 31'h7FFF_FFFF, 0);  // absent pid
		send_cmd(OP_KILL, 0, 31'd0, 0);          // unused slots never match
		send_cmd(OP_KILL, 0, 31'd1, 0);
		send_cmd(OP_PICK, 0, 0, 0);
		send_cmd(OP_EXIT, 0, 0, 0);
		send_cmd(OP_EXIT, 0, 0, 0);              // wrong state
		send_cmd(OP_TICK, 0, 0, 0);
		send_cmd(OP_REAP, 0, 0, 0);
		send_cmd(4'd10, 0, 0, 0);
		send_cmd(4'd15, 6'd63, 0, 0);

		// Fill the table to exercise the no-free-slot path.
		repeat (65) send_cmd(OP_ALLOC, 0, 0, 0);
		for (int i = 0; i < NUM_SLOTS; i++) send_cmd(OP_RUNNABLE, 6'(i), 0, 0);

		// Policy sweep, each with random traffic; extremes of quantum included.
		write_reg(CFG_QUANTUM, 8'd1);
		random_phase(200);
		write_reg(CFG_POLICY, POL_PRIO);
		random_phase(200);
		write_reg(CFG_POLICY, POL_RR_Q);
		write_reg(CFG_QUANTUM, 8'd255);
		stall_on = 0;
		random_phase(200);
		stall_on = 1;
		write_reg(CFG_QUANTUM, 8'd0);
		random_phase(150);
		write_reg(CFG_QUANTUM, 8'd3);
		random_phase(150);
		write_reg(CFG_POLICY, 2'd3);
		random_phase(125);
		write_reg(CFG_POLICY, 2'd0);
		write_reg(CFG_QUANTUM, 8'hAA);
		random_phase(125);

		idle_gap(1);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("covered %0d result beats: alloc %0d pick %0d tick %0d reap %0d",
			board.checked, n_ops[OP_ALLOC], n_ops[OP_PICK], n_ops[OP_TICK], n_ops[OP_REAP]);
		$display("policies 0..3 and quantum 0, 1, 3, 170, 255 with bursty sends and stalls");
		if (board.errors == 0 && board.pending.size() == 0)
			$display("process_table_scheduler: match");
		else
			$display("process_table_scheduler: mismatch");
		$finish;
	end

	// Watchdog: ~1300 beats at their worst-case sweep time, several times over.
	initial begin
		#20ms;
		$display("process_table_scheduler: mismatch");
		$finish;
	end
endmodule

@@ process_table_scheduler.f @@
src/pts_pkg.sv
src/pts_front.sv
src/pts_engine.sv
src/pts_outq.sv
src/process_table_scheduler.sv
sim/tb.sv
